// ===== sv/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants of the per-pixel color unit: payload structs,
// operation codes, hue sector codes and the divider geometry.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    // Operation codes of the mode register
    localparam logic [2:0] OP_INV_RGB   = 3'd0;
    localparam logic [2:0] OP_INV_ALPHA = 3'd1;
    localparam logic [2:0] OP_INV_ALL   = 3'd2;
    localparam logic [2:0] OP_CLR_R     = 3'd3;
    localparam logic [2:0] OP_CLR_G     = 3'd4;
    localparam logic [2:0] OP_CLR_B     = 3'd5;
    localparam logic [2:0] OP_HSV       = 3'd6;

    // Hue sector, named after the channel that holds the maximum
    localparam logic [1:0] SEC_BLUE  = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_RED   = 2'd2;

    // Divider geometry: 17-bit dividend, 9-bit divisor, 8-bit quotient
    localparam int NUM_W = 17;
    localparam int DEN_W = 9;
    localparam int QUO_W = 8;

    // Hue scaling: H = floor((255*h + 180) / 360) by reciprocal and correction
    localparam int             H_SHIFT = 17;
    localparam logic [8:0]     H_RECIP = 9'((1 << H_SHIFT) / 360);
    localparam logic [8:0]     H_DIV   = 9'd360;
    localparam logic [9:0]     H_DIV2  = 10'd720;
    localparam logic [7:0]     H_MAX   = 8'd254;
    localparam logic [7:0]     Q_MAX   = 8'd60;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic [7:0] alpha_in;
        logic       last_in;
    } in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic [7:0] alpha_out;
        logic       last_out;
    } out_t;

    // Item context that rides along the pipeline
    typedef struct packed {
        out_t       pix;     // result of the simple operations
        logic       hsv;     // item is converted to HSV
        logic [7:0] v;       // maximum channel
        logic [1:0] sec;     // hue sector
        logic       neg;     // hue offset is negative
        logic       dzero;   // grey pixel
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num_s;
        logic [DEN_W-1:0] den_s;
        logic [NUM_W-1:0] num_q;
        logic [DEN_W-1:0] den_q;
        side_t            side;
    } div_in_t;

    typedef struct packed {
        logic [QUO_W-1:0] quo_s;
        logic [QUO_W-1:0] quo_q;
        side_t            side;
    } div_out_t;

endpackage

// ===== sv/pixel_color_ops_rgb_to_hsv_unit.sv =====
// Throughput: one item per cycle while the output is not stalled; every
// stage is a register with its own valid bit, so a bubble is filled while a
// result waits at the output.
// The hue/saturation path runs through an eight-stage bit-per-stage divider.
// Reset (aresetn, synchronous, active low) empties the pipeline and selects
// the invert RGB operation.
// ----------------------------------------------------------------------------
// pixel_color_ops_rgb_to_hsv_unit
// Per-pixel BGRA operations: channel inversion, channel clearing and RGB to
// HSV conversion, selected by the operation register.
// ----------------------------------------------------------------------------
module pixel_color_ops_rgb_to_hsv_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  rgbhsv_pkg::in_t     s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rgbhsv_pkg::out_t    m_data
);

    logic [2:0]           op_reg;

    logic                 a_vld_reg;
    rgbhsv_pkg::side_t    a_side_reg;
    rgbhsv_pkg::side_t    a_side_next;
    logic [7:0]           a_d_reg;
    logic [7:0]           a_d_next;
    logic [7:0]           a_mag_reg;
    logic [7:0]           a_mag_next;
    logic                 a_rdy;

    logic                 b_vld_reg;
    rgbhsv_pkg::div_in_t  b_data_reg;
    rgbhsv_pkg::div_in_t  b_data_next;
    logic                 b_rdy;

    logic                 div_in_ready;
    logic                 div_out_valid;
    rgbhsv_pkg::div_out_t div_out;

    logic                 c_vld_reg;
    rgbhsv_pkg::side_t    c_side_reg;
    logic [7:0]           c_s_reg;
    logic [16:0]          c_nh_reg;
    logic [16:0]          c_nh_next;
    logic                 c_rdy;

    logic                 d_vld_reg;
    rgbhsv_pkg::side_t    d_side_reg;
    logic [7:0]           d_s_reg;
    logic [16:0]          d_nh_reg;
    logic [7:0]           d_q0_reg;
    logic [25:0]          d_prod;
    logic                 d_rdy;

    logic                 e_vld_reg;
    rgbhsv_pkg::side_t    e_side_reg;
    logic [7:0]           e_s_reg;
    logic [7:0]           e_q0_reg;
    logic [9:0]           e_rem_reg;
    logic [16:0]          e_rem_next;
    logic                 e_rdy;

    logic                 m_valid_reg;
    rgbhsv_pkg::out_t     m_data_reg;
    rgbhsv_pkg::out_t     m_data_next;
    logic                 m_rdy;

    // Operation register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= rgbhsv_pkg::OP_INV_RGB;
        end else if (cfg_wr_en) begin
            op_reg <= cfg_wr_data;
        end
    end

    // Ready chain: a stage takes a new item when empty or when it drains
    assign m_rdy   = !m_valid_reg || m_ready;
    assign e_rdy   = !e_vld_reg || m_rdy;
    assign d_rdy   = !d_vld_reg || e_rdy;
    assign c_rdy   = !c_vld_reg || d_rdy;
    assign b_rdy   = !b_vld_reg || div_in_ready;
    assign a_rdy   = !a_vld_reg || b_rdy;
    assign s_ready = a_rdy;

    // Stage A: simple operations, max/min, sector and hue offset magnitude
    always_comb begin
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] vmax;
        logic [7:0] vmin;
        logic [1:0] sec;
        logic       neg;
        logic [7:0] mag;

        b = s_data.blue_in;
        g = s_data.green_in;
        r = s_data.red_in;

        a_side_next.pix.blue_out  = b;
        a_side_next.pix.green_out = g;
        a_side_next.pix.red_out   = r;
        a_side_next.pix.alpha_out = s_data.alpha_in;
        a_side_next.pix.last_out  = s_data.last_in;
        case (op_reg)
            rgbhsv_pkg::OP_INV_RGB: begin
                a_side_next.pix.blue_out  = ~b;
                a_side_next.pix.green_out = ~g;
                a_side_next.pix.red_out   = ~r;
            end
            rgbhsv_pkg::OP_INV_ALPHA: begin
                a_side_next.pix.alpha_out = ~s_data.alpha_in;
            end
            rgbhsv_pkg::OP_INV_ALL: begin
                a_side_next.pix.blue_out  = ~b;
                a_side_next.pix.green_out = ~g;
                a_side_next.pix.red_out   = ~r;
                a_side_next.pix.alpha_out = ~s_data.alpha_in;
            end
            rgbhsv_pkg::OP_CLR_R: a_side_next.pix.red_out   = '0;
            rgbhsv_pkg::OP_CLR_G: a_side_next.pix.green_out = '0;
            rgbhsv_pkg::OP_CLR_B: a_side_next.pix.blue_out  = '0;
            default: ;
        endcase

        // Blue is the default maximum; ties keep the earlier channel
        sec  = rgbhsv_pkg::SEC_BLUE;
        vmax = b;
        vmin = g;
        if (g > b) begin
            sec  = rgbhsv_pkg::SEC_GREEN;
            vmax = g;
            vmin = b;
        end
        if (r > vmax) begin
            sec  = rgbhsv_pkg::SEC_RED;
            vmax = r;
        end else if (r < vmin) begin
            vmin = r;
        end

        case (sec)
            rgbhsv_pkg::SEC_RED: begin
                neg = (g < b);
                mag = neg ? (b - g) : (g - b);
            end
            rgbhsv_pkg::SEC_GREEN: begin
                neg = (b < r);
                mag = neg ? (r - b) : (b - r);
            end
            default: begin
                neg = (r < g);
                mag = neg ? (g - r) : (r - g);
            end
        endcase

        a_d_next          = vmax - vmin;
        a_mag_next        = mag;
        a_side_next.hsv   = (op_reg == rgbhsv_pkg::OP_HSV);
        a_side_next.v     = vmax;
        a_side_next.sec   = sec;
        a_side_next.neg   = neg;
        a_side_next.dzero = (a_d_next == 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (a_rdy) begin
            a_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy) begin
            a_side_reg <= a_side_next;
            a_d_reg    <= a_d_next;
            a_mag_reg  <= a_mag_next;
        end
    end

    // Stage B: dividends and divisors for saturation and hue offset
    always_comb begin
        b_data_next.num_s = 17'(a_d_reg) * 17'd510 + 17'(a_side_reg.v);
        b_data_next.den_s = {a_side_reg.v, 1'b0};
        b_data_next.num_q = 17'(a_mag_reg) * 17'd60;
        b_data_next.den_q = 9'(a_d_reg);
        b_data_next.side  = a_side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (b_rdy) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_rdy) begin
            b_data_reg <= b_data_next;
        end
    end

    rgbhsv_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_vld_reg),
        .in_ready  (div_in_ready),
        .in_data   (b_data_reg),
        .out_valid (div_out_valid),
        .out_ready (c_rdy),
        .out_data  (div_out)
    );

    // Stage C: sector hue in degrees, then the scaled numerator 255*h + 180
    always_comb begin
        logic [8:0] q;
        logic [8:0] h;

        q = 9'(div_out.quo_q);
        case (div_out.side.sec)
            rgbhsv_pkg::SEC_RED:   h = div_out.side.neg ? (9'd360 - q) : q;
            rgbhsv_pkg::SEC_GREEN: h = div_out.side.neg ? (9'd120 - q) : (9'd120 + q);
            default:               h = div_out.side.neg ? (9'd240 - q) : (9'd240 + q);
        endcase
        // Grey pixel, and a red-sector offset of minus zero, give hue 0
        if (div_out.side.dzero || h >= rgbhsv_pkg::H_DIV) begin
            h = '0;
        end
        c_nh_next = (17'(h) << 8) - 17'(h) + 17'd180;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (c_rdy) begin
            c_vld_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_rdy) begin
            c_side_reg <= div_out.side;
            c_s_reg    <= div_out.quo_s;
            c_nh_reg   <= c_nh_next;
        end
    end

    // Stage D: quotient estimate by the reciprocal of 360, low by at most one
    assign d_prod = 26'(c_nh_reg) * 26'(rgbhsv_pkg::H_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (d_rdy) begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_rdy) begin
            d_side_reg <= c_side_reg;
            d_s_reg    <= c_s_reg;
            d_nh_reg   <= c_nh_reg;
            d_q0_reg   <= d_prod[24:17];
        end
    end

    // Stage E: remainder of the estimate
    assign e_rem_next = d_nh_reg - 17'(d_q0_reg) * 17'(rgbhsv_pkg::H_DIV);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (e_rdy) begin
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_rdy) begin
            e_side_reg <= d_side_reg;
            e_s_reg    <= d_s_reg;
            e_q0_reg   <= d_q0_reg;
            e_rem_reg  <= e_rem_next[9:0];
        end
    end

    // Output stage: correct the hue and pack the result item
    always_comb begin
        logic [7:0] hue;

        hue = e_q0_reg + 8'(e_rem_reg >= 10'(rgbhsv_pkg::H_DIV));
        m_data_next = e_side_reg.pix;
        if (e_side_reg.hsv) begin
            m_data_next.blue_out  = e_side_reg.v;
            m_data_next.green_out = (e_side_reg.v == 8'd0) ? 8'd0 : e_s_reg;
            m_data_next.red_out   = hue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_rdy) begin
            m_valid_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_rdy) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Input backpressure only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the pipeline has room");

    // Hue offset quotient never exceeds 60 degrees for a colored pixel
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_out_valid && !div_out.side.dzero) |-> (div_out.quo_q <= rgbhsv_pkg::Q_MAX))
        else $error("hue offset quotient out of range");

    // Reciprocal estimate is at most one below the exact quotient
    a_hue_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        e_vld_reg |-> (e_rem_reg < rgbhsv_pkg::H_DIV2))
        else $error("hue remainder needs more than one correction");

    // Scaled hue stays within 0..254
    a_hue_max: assert property (@(posedge aclk) disable iff (!aresetn)
        e_vld_reg |-> (e_q0_reg <= rgbhsv_pkg::H_MAX))
        else $error("hue estimate out of range");
`endif

endmodule

// ===== sv/rgbhsv_div.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_div
// Two-lane pipelined restoring divider, one quotient bit per stage. Lane S
// yields saturation, lane Q the hue offset. Each dividend must be below 256
// times its divisor. Item context travels with the quotients.
// ----------------------------------------------------------------------------
module rgbhsv_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rgbhsv_pkg::div_in_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgbhsv_pkg::div_out_t out_data
);

    localparam int NW = rgbhsv_pkg::NUM_W;
    localparam int DW = rgbhsv_pkg::DEN_W;
    localparam int QW = rgbhsv_pkg::QUO_W;

    logic                  vld_reg  [QW];
    logic                  ready_w  [QW+1];
    logic [NW-1:0]         rs_reg   [QW];
    logic [NW-1:0]         rs_next  [QW];
    logic [NW-1:0]         rq_reg   [QW];
    logic [NW-1:0]         rq_next  [QW];
    logic [DW-1:0]         ds_reg   [QW];
    logic [DW-1:0]         dq_reg   [QW];
    logic [QW-1:0]         qs_reg   [QW];
    logic [QW-1:0]         qs_next  [QW];
    logic [QW-1:0]         qq_reg   [QW];
    logic [QW-1:0]         qq_next  [QW];
    rgbhsv_pkg::side_t     side_reg [QW];

    assign ready_w[QW] = out_ready;
    assign in_ready    = ready_w[0];

    for (genvar i = 0; i < QW; i++) begin : g_step
        localparam int SH = QW - 1 - i;

        logic              src_vld;
        logic [NW-1:0]     src_rs;
        logic [NW-1:0]     src_rq;
        logic [DW-1:0]     src_ds;
        logic [DW-1:0]     src_dq;
        logic [QW-1:0]     src_qs;
        logic [QW-1:0]     src_qq;
        rgbhsv_pkg::side_t src_side;
        logic [NW-1:0]     sub_s;
        logic [NW-1:0]     sub_q;
        logic              ge_s;
        logic              ge_q;

        // Pick up the item from the input or the previous stage
        if (i == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_rs   = in_data.num_s;
            assign src_rq   = in_data.num_q;
            assign src_ds   = in_data.den_s;
            assign src_dq   = in_data.den_q;
            assign src_qs   = '0;
            assign src_qq   = '0;
            assign src_side = in_data.side;
        end else begin : g_later
            assign src_vld  = vld_reg[i-1];
            assign src_rs   = rs_reg[i-1];
            assign src_rq   = rq_reg[i-1];
            assign src_ds   = ds_reg[i-1];
            assign src_dq   = dq_reg[i-1];
            assign src_qs   = qs_reg[i-1];
            assign src_qq   = qq_reg[i-1];
            assign src_side = side_reg[i-1];
        end

        // Trial subtract of the shifted divisor, set one quotient bit
        assign sub_s = NW'(src_ds) << SH;
        assign sub_q = NW'(src_dq) << SH;
        assign ge_s  = (src_rs >= sub_s);
        assign ge_q  = (src_rq >= sub_q);

        assign rs_next[i] = ge_s ? (src_rs - sub_s) : src_rs;
        assign rq_next[i] = ge_q ? (src_rq - sub_q) : src_rq;
        assign qs_next[i] = src_qs | (QW'(ge_s) << SH);
        assign qq_next[i] = src_qq | (QW'(ge_q) << SH);

        // Advance when the stage is empty or its item moves on
        assign ready_w[i] = !vld_reg[i] || ready_w[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (ready_w[i]) begin
                vld_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (ready_w[i]) begin
                rs_reg[i]   <= rs_next[i];
                rq_reg[i]   <= rq_next[i];
                ds_reg[i]   <= src_ds;
                dq_reg[i]   <= src_dq;
                qs_reg[i]   <= qs_next[i];
                qq_reg[i]   <= qq_next[i];
                side_reg[i] <= src_side;
            end
        end
    end

    assign out_valid      = vld_reg[QW-1];
    assign out_data.quo_s = qs_reg[QW-1];
    assign out_data.quo_q = qq_reg[QW-1];
    assign out_data.side  = side_reg[QW-1];

endmodule
